@@ rtl/rhc_pkg.sv @@
// shared constants for the rgb to hsl converter and its pipelined divider
`timescale 1ns / 1ps
`default_nettype none

package rhc_pkg;

    // channel and result field widths
    localparam int CHAN_W  = 8;
    localparam int HUE_W   = 9;
    localparam int PCT_W   = 7;

    // divider geometry: quotient bits, divisor bits, working width, bits per stage
    localparam int DIV_QW     = 9;
    localparam int DIV_DW     = 10;
    localparam int DIV_W      = DIV_QW + DIV_DW;
    localparam int DIV_BPS    = 2;
    localparam int DIV_STAGES = (DIV_QW + DIV_BPS - 1) / DIV_BPS;

    // lightness is round(100 * sum / 510), done as (200 * sum + 510) / 1020
    localparam logic [DIV_W-1:0]  LIGHT_BIAS = DIV_W'(510);
    localparam logic [DIV_DW-1:0] LIGHT_DEN  = DIV_DW'(1020);

endpackage

`default_nettype wire

@@ rtl/rhc_if.sv @@
// valid/ready channel interfaces for rgb pixels in and hsl results out
`timescale 1ns / 1ps
`default_nettype none

interface rhc_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rhc_hsl_if;
    logic       valid;
    logic       ready;
    logic [8:0] hue;
    logic [6:0] saturation;
    logic [6:0] lightness;

    modport source (output valid, output hue, output saturation, output lightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input lightness,
                    output ready);
endinterface

`default_nettype wire

@@ rtl/rhc_div.sv @@
// pipelined restoring divider, a fixed number of quotient bits per stage
`timescale 1ns / 1ps
`default_nettype none

module rhc_div (
    input  wire logic                             i_clk,
    input  wire logic [rhc_pkg::DIV_STAGES-1:0]   i_en,
    input  wire logic [rhc_pkg::DIV_W-1:0]        i_num,
    input  wire logic [rhc_pkg::DIV_DW-1:0]       i_den,
    output      logic [rhc_pkg::DIV_QW-1:0]       o_quo
);

    localparam int QW  = rhc_pkg::DIV_QW;
    localparam int DW  = rhc_pkg::DIV_DW;
    localparam int W   = rhc_pkg::DIV_W;
    localparam int BPS = rhc_pkg::DIV_BPS;
    localparam int NS  = rhc_pkg::DIV_STAGES;

    logic [W-1:0]  r_rem [NS];
    logic [QW-1:0] r_quo [NS];
    logic [DW-1:0] r_den [NS];

    for (genvar s = 0; s < NS; s++) begin : g_stage
        logic [W-1:0]  rem_in;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [W-1:0]  n_rem;
        logic [QW-1:0] n_quo;

        // stage inputs come from the port or the previous stage
        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign quo_in = r_quo[s-1];
            assign den_in = r_den[s-1];
        end

        // trial subtract of the shifted divisor, msb first
        always_comb begin
            n_rem = rem_in;
            n_quo = quo_in;
            for (int j = 0; j < BPS; j++) begin
                if (QW - 1 - s * BPS - j >= 0) begin
                    if (n_rem >= (W'(den_in) << (QW - 1 - s * BPS - j))) begin
                        n_rem = n_rem - (W'(den_in) << (QW - 1 - s * BPS - j));
                        n_quo[QW - 1 - s * BPS - j] = 1'b1;
                    end
                end
            end
        end

        // stage registers advance only when the stage may move
        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem;
                r_quo[s] <= n_quo;
                r_den[s] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[NS-1];

endmodule

`default_nettype wire

@@ rtl/rgb_to_hsl_converter.sv @@
// top level: pipelined rgb to hsl conversion, one pixel per clock unless the output stalls
`timescale 1ns / 1ps
`default_nettype none

// Converts one 8-bit rgb pixel per clock into hue (0..360 degrees) and
// saturation and lightness (0..100 percent), each rounded to nearest with
// halves up and exact to the bit. Throughput is one pixel per cycle unless
// the output stalls. One stage finds the max, min and hue sector, one builds
// the three numerators and divisors, and the remaining stages are three
// parallel restoring dividers retiring up to two quotient bits per stage.
// Each stage advances on its own when its successor has room, so bubbles
// collapse and a stalled output only holds back the stages that are full.
// i_pix.ready depends combinationally on o_hsl.ready through the stage
// ready chain.

module rgb_to_hsl_converter (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rhc_pix_if.sink    i_pix,
    rhc_hsl_if.source  o_hsl
);

    localparam int NSTG = 2 + rhc_pkg::DIV_STAGES;
    localparam int W    = rhc_pkg::DIV_W;
    localparam int DW   = rhc_pkg::DIV_DW;
    localparam int CW   = rhc_pkg::CHAN_W;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_RED_WRAP,
        SECT_GREEN,
        SECT_BLUE
    } t_sector;

    logic [NSTG-1:0] r_valid;
    logic [NSTG-1:0] en;

    // stage 0 registers
    logic [CW-1:0]       r_s0_hi;
    logic [CW-1:0]       r_s0_lo;
    logic signed [CW:0]  r_s0_x;
    t_sector             r_s0_sect;

    // stage 1 registers
    logic [W-1:0]  r_s1_hnum;
    logic [DW-1:0] r_s1_hden;
    logic [W-1:0]  r_s1_snum;
    logic [DW-1:0] r_s1_sden;
    logic [W-1:0]  r_s1_lnum;

    // stage 0 next values
    logic [CW-1:0]      n_s0_hi;
    logic [CW-1:0]      n_s0_lo;
    logic signed [CW:0] n_s0_x;
    t_sector            n_s0_sect;

    // stage 1 next values
    logic [W-1:0]   n_s1_hnum;
    logic [DW-1:0]  n_s1_hden;
    logic [W-1:0]   n_s1_snum;
    logic [DW-1:0]  n_s1_sden;
    logic [W-1:0]   n_s1_lnum;
    logic [CW-1:0]  diff;
    logic [CW:0]    sum;
    logic [CW-1:0]  sden;
    logic [19:0]    h_off;
    logic signed [20:0] h_acc;

    logic [rhc_pkg::DIV_QW-1:0] hue_q;
    logic [rhc_pkg::DIV_QW-1:0] sat_q;
    logic [rhc_pkg::DIV_QW-1:0] light_q;

    // per-stage advance: a stage moves when empty or when its successor moves
    always_comb begin
        en[NSTG-1] = !r_valid[NSTG-1] || o_hsl.ready;
        for (int s = NSTG - 2; s >= 0; s--) begin
            en[s] = !r_valid[s] || en[s+1];
        end
    end

    assign i_pix.ready = en[0];

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            if (en[0]) begin
                r_valid[0] <= i_pix.valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (en[s]) begin
                    r_valid[s] <= r_valid[s-1];
                end
            end
        end
    end

    // max, min and hue sector; ties go to red, then green
    always_comb begin
        n_s0_hi = i_pix.red;
        n_s0_lo = i_pix.red;
        if (i_pix.green > n_s0_hi) n_s0_hi = i_pix.green;
        if (i_pix.blue  > n_s0_hi) n_s0_hi = i_pix.blue;
        if (i_pix.green < n_s0_lo) n_s0_lo = i_pix.green;
        if (i_pix.blue  < n_s0_lo) n_s0_lo = i_pix.blue;
        if (i_pix.red >= i_pix.green && i_pix.red >= i_pix.blue) begin
            n_s0_sect = (i_pix.green < i_pix.blue) ? SECT_RED_WRAP : SECT_RED;
            n_s0_x    = $signed({1'b0, i_pix.green}) - $signed({1'b0, i_pix.blue});
        end else if (i_pix.green >= i_pix.blue) begin
            n_s0_sect = SECT_GREEN;
            n_s0_x    = $signed({1'b0, i_pix.blue}) - $signed({1'b0, i_pix.red});
        end else begin
            n_s0_sect = SECT_BLUE;
            n_s0_x    = $signed({1'b0, i_pix.red}) - $signed({1'b0, i_pix.green});
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_s0_hi   <= n_s0_hi;
            r_s0_lo   <= n_s0_lo;
            r_s0_x    <= n_s0_x;
            r_s0_sect <= n_s0_sect;
        end
    end

    // numerators and divisors, everything doubled so rounding is a floor
    always_comb begin
        diff = r_s0_hi - r_s0_lo;
        sum  = {1'b0, r_s0_hi} + {1'b0, r_s0_lo};
        sden = (sum > (CW+1)'(255)) ? CW'((CW+1)'(510) - sum) : sum[CW-1:0];

        // doubled hue sector offset 240*k*d plus the half-step d
        case (r_s0_sect)
            SECT_RED:      h_off = 20'(diff);
            SECT_RED_WRAP: h_off = 20'(diff) * 20'd721;
            SECT_GREEN:    h_off = 20'(diff) * 20'd241;
            SECT_BLUE:     h_off = 20'(diff) * 20'd481;
            default:       h_off = '0;
        endcase
        h_acc = $signed({{12{r_s0_x[CW]}}, r_s0_x}) * 21'sd120 + $signed({1'b0, h_off});

        // grey pixel: hue and saturation divide zero by one
        if (diff == '0) begin
            n_s1_hnum = '0;
            n_s1_hden = DW'(1);
            n_s1_snum = '0;
            n_s1_sden = DW'(1);
        end else begin
            n_s1_hnum = h_acc[W-1:0];
            n_s1_hden = DW'({diff, 1'b0});
            n_s1_snum = W'(diff) * W'(200) + W'(sden);
            n_s1_sden = DW'({sden, 1'b0});
        end
        n_s1_lnum = W'(sum) * W'(200) + rhc_pkg::LIGHT_BIAS;
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_s1_hnum <= n_s1_hnum;
            r_s1_hden <= n_s1_hden;
            r_s1_snum <= n_s1_snum;
            r_s1_sden <= n_s1_sden;
            r_s1_lnum <= n_s1_lnum;
        end
    end

    // three dividers in lockstep
    rhc_div u_hue_div (
        .i_clk (i_clk),
        .i_en  (en[NSTG-1:2]),
        .i_num (r_s1_hnum),
        .i_den (r_s1_hden),
        .o_quo (hue_q)
    );

    rhc_div u_sat_div (
        .i_clk (i_clk),
        .i_en  (en[NSTG-1:2]),
        .i_num (r_s1_snum),
        .i_den (r_s1_sden),
        .o_quo (sat_q)
    );

    rhc_div u_light_div (
        .i_clk (i_clk),
        .i_en  (en[NSTG-1:2]),
        .i_num (r_s1_lnum),
        .i_den (rhc_pkg::LIGHT_DEN),
        .o_quo (light_q)
    );

    // result transfer
    assign o_hsl.valid      = r_valid[NSTG-1];
    assign o_hsl.hue        = hue_q[rhc_pkg::HUE_W-1:0];
    assign o_hsl.saturation = sat_q[rhc_pkg::PCT_W-1:0];
    assign o_hsl.lightness  = light_q[rhc_pkg::PCT_W-1:0];

    // reset empties the whole pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> r_valid == '0)
        else $error("pipeline not empty after reset");

    // input is refused only when every stage holds an item
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> (&r_valid) && !o_hsl.ready)
        else $error("input stalled with room in the pipeline");

    // a grey pixel gives zero hue and saturation numerators
    a_grey_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[0] && en[1] && r_s0_hi == r_s0_lo |=> r_s1_hnum == '0 && r_s1_snum == '0)
        else $error("grey pixel with nonzero numerator");

    // results stay in range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid[NSTG-1] |-> hue_q <= 9'd360 && sat_q <= 9'd100 && light_q <= 9'd100)
        else $error("result out of range");

endmodule

`default_nettype wire

@@ sim/rgb_to_hsl_converter_tb.sv @@
// self-checking testbench for the rgb to hsl converter: directed corners, random pixels, stalls
`timescale 1ns / 1ps

module rgb_to_hsl_converter_tb;

    localparam int RANDOM_PIXELS   = 1850;
    localparam int MAX_GAP         = 12;
    localparam int CALM_PERIOD     = 150;
    localparam int HOLD_AFTER      = 400;
    localparam int HOLD_CYCLES     = 120;
    localparam int DRAIN_CYCLES    = 12;
    localparam int STALL_LIMIT     = 2000;

    typedef struct packed {
        logic [rhc_pkg::CHAN_W-1:0] red;
        logic [rhc_pkg::CHAN_W-1:0] green;
        logic [rhc_pkg::CHAN_W-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [rhc_pkg::HUE_W-1:0] hue;
        logic [rhc_pkg::PCT_W-1:0] saturation;
        logic [rhc_pkg::PCT_W-1:0] lightness;
    } t_hsl;

    // corner pixels: black, white, greys, primaries, secondaries, hue wrap to 360,
    // max ties, halves in saturation and hue, both saturation denominators
    localparam logic [23:0] CORNER_RGB [0:23] = '{
        24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
        24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
        24'h00FFFF, 24'hFF00FF, 24'hFF0001, 24'hC8C832,
        24'h32C8C8, 24'hC832C8, 24'h292827, 24'h0A0302,
        24'hC86496, 24'hFE0100, 24'h7F8000, 24'h807F7F,
        24'h808081, 24'hFF7F00, 24'h01FE80, 24'h0080FF
    };

    localparam logic [7:0] EDGE_VALS [0:5] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};

    // expected hsl results in transfer order, with the conversion that yields them
    class hsl_ledger;
        t_hsl due[$];
        int   mismatches;

        function new();
            mismatches = 0;
        endfunction

        static function int round_half_up(int num, int den);
            return (2 * num + den) / (2 * den);
        endfunction

        // exact conversion of one pixel
        static function t_hsl pixel_to_hsl(t_pixel p);
            int   r, g, b, hi, lo, span, total, den, num;
            t_hsl o;
            r = p.red;
            g = p.green;
            b = p.blue;
            hi = (r > g) ? r : g;
            hi = (b > hi) ? b : hi;
            lo = (r < g) ? r : g;
            lo = (b < lo) ? b : lo;
            span  = hi - lo;
            total = hi + lo;
            o.lightness  = rhc_pkg::PCT_W'(round_half_up(100 * total, 510));
            o.saturation = '0;
            o.hue        = '0;
            if (span > 0) begin
                den = (total > 255) ? 510 - total : total;
                o.saturation = rhc_pkg::PCT_W'(round_half_up(100 * span, den));
                // red wins ties over green, green over blue
                if (hi == r) begin
                    num = 60 * (g - b) + ((g < b) ? 360 * span : 0);
                end else if (hi == g) begin
                    num = 60 * (b - r) + 120 * span;
                end else begin
                    num = 60 * (r - g) + 240 * span;
                end
                o.hue = rhc_pkg::HUE_W'(round_half_up(num, span));
            end
            return o;
        endfunction

        task flag_mismatch(string what);
            mismatches++;
            $display("[%0t] mismatch: %s", $time, what);
        endtask

        function void note_pixel(t_pixel p);
            due.push_back(pixel_to_hsl(p));
        endfunction

        task check_hsl(t_hsl got);
            t_hsl want;
            if (due.size() == 0) begin
                flag_mismatch($sformatf("unexpected result hue %0d sat %0d light %0d",
                                        got.hue, got.saturation, got.lightness));
            end else begin
                want = due.pop_front();
                if (got.hue !== want.hue)
                    flag_mismatch($sformatf("hue got %0d want %0d", got.hue, want.hue));
                if (got.saturation !== want.saturation)
                    flag_mismatch($sformatf("saturation got %0d want %0d",
                                            got.saturation, want.saturation));
                if (got.lightness !== want.lightness)
                    flag_mismatch($sformatf("lightness got %0d want %0d",
                                            got.lightness, want.lightness));
            end
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    rhc_pix_if pix ();
    rhc_hsl_if hsl ();

    rgb_to_hsl_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (pix),
        .o_hsl   (hsl)
    );

    hsl_ledger ledger;
    int        results_seen;
    int        quiet_cycles;
    bit        sender_calm;
    bit        receiver_calm;
    bit        output_held;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // random pixel: mostly uniform, plus near-grey, ties, greys and edge values
    function automatic t_pixel random_pixel();
        t_pixel p;
        int     kind, base;
        p    = t_pixel'(24'($urandom));
        kind = $urandom_range(0, 9);
        case (kind)
            5: begin
                base    = $urandom_range(0, 252);
                p.red   = 8'(base + $urandom_range(0, 3));
                p.green = 8'(base + $urandom_range(0, 3));
                p.blue  = 8'(base + $urandom_range(0, 3));
            end
            6: p.green = p.red;
            7: p.blue = ($urandom_range(0, 1) == 1) ? p.green : p.red;
            8: begin
                p.green = p.red;
                p.blue  = p.red;
            end
            9: begin
                p.red   = EDGE_VALS[$urandom_range(0, 5)];
                p.green = EDGE_VALS[$urandom_range(0, 5)];
                p.blue  = EDGE_VALS[$urandom_range(0, 5)];
            end
            default: ;
        endcase
        return p;
    endfunction

    // offer one pixel after a drawn gap and wait for its transfer
    task automatic send_pixel(t_pixel p);
        int gap;
        gap = (sender_calm || output_held) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            pix.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix.valid <= 1'b1;
        pix.red   <= p.red;
        pix.green <= p.green;
        pix.blue  <= p.blue;
        do @(posedge i_clk); while (!pix.ready);
    endtask

    // result side: random back-pressure, one long hold to fill the pipeline
    initial begin : receiver
        int gap;
        int since_calm;
        bit held_once;
        hsl.ready     <= 1'b0;
        receiver_calm = 1'b0;
        output_held   = 1'b0;
        held_once     = 1'b0;
        since_calm    = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (++since_calm >= CALM_PERIOD) begin
                since_calm    = 0;
                receiver_calm = ($urandom_range(0, 3) == 0);
            end
            gap = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (!held_once && results_seen >= HOLD_AFTER) begin
                held_once   = 1'b1;
                output_held = 1'b1;
                hsl.ready  <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                output_held = 1'b0;
            end else if (gap > 0) begin
                hsl.ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            hsl.ready <= 1'b1;
            do @(posedge i_clk); while (!hsl.valid);
        end
    end

    // transfer monitor: note accepted pixels, check results, watch for a hang
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hsl.valid && hsl.ready) begin
                ledger.check_hsl('{hue: hsl.hue, saturation: hsl.saturation,
                                   lightness: hsl.lightness});
                results_seen++;
            end
            if (pix.valid && pix.ready)
                ledger.note_pixel('{red: pix.red, green: pix.green, blue: pix.blue});
            if ((hsl.valid && hsl.ready) || (pix.valid && pix.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    // reset, stimulus and end of run
    initial begin : stimulus
        ledger       = new();
        results_seen = 0;
        quiet_cycles = 0;
        sender_calm  = 1'b0;
        i_rst_n   <= 1'b0;
        pix.valid <= 1'b0;
        pix.red   <= '0;
        pix.green <= '0;
        pix.blue  <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (CORNER_RGB[i])
            send_pixel(t_pixel'(CORNER_RGB[i]));

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            if (n % CALM_PERIOD == 0)
                sender_calm = ($urandom_range(0, 3) == 0);
            send_pixel(random_pixel());
        end
        pix.valid <= 1'b0;

        // drain, then give a stray result time to show up
        while (ledger.due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (ledger.due.size() != 0)
            ledger.flag_mismatch($sformatf("%0d results never arrived", ledger.due.size()));
        if (ledger.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/rhc_pkg.sv
rtl/rhc_if.sv
rtl/rhc_div.sv
rtl/rgb_to_hsl_converter.sv
sim/rgb_to_hsl_converter_tb.sv
